// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clk_i edge, off while rst_ni is low.
`define SLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must never hold.
`define SLE_ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ----- rtl/core/sle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;

  localparam int unsigned DefCapacity = 16;

  // command codes
  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_DEL_HD  = 3'd2;
  localparam logic [2:0] CMD_SEARCH  = 3'd3;
  localparam logic [2:0] CMD_DEL_KEY = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand;
  } sle_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         position;
    logic [4:0]         entry_count;
  } sle_res_t;

  // what every cell does in a cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_ge;   // load flag on entry >= key, else on entry == key
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/sle_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sle_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sle_pkg::cell_ctl_t ctl_i,
  input  wire logic [CW-1:0]      idx_i,
  input  wire logic [CW-1:0]      count_i,
  input  wire logic signed [31:0] key_i,
  input  wire logic signed [31:0] prev_val_i,
  input  wire logic signed [31:0] next_val_i,
  input  wire logic               next_flag_i,
  output logic signed [31:0]      val_o,
  output logic                    flag_o
);
  import sle_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(INDEX);

  logic signed [31:0] val_q, val_d;
  logic               flag_q, flag_d;

  always_comb begin
    val_d  = val_q;
    flag_d = flag_q;
    unique case (ctl_i.op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        flag_d = (MyIdx < count_i) &&
                 (ctl_i.cmp_ge ? !(val_q < key_i) : (val_q == key_i));
      end
      OP_SHIFT: begin
        flag_d = next_flag_i;
      end
      OP_INSERT: begin
        if (MyIdx == idx_i) begin
          val_d = key_i;
        end else if (MyIdx > idx_i) begin
          val_d = prev_val_i;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= idx_i) begin
          val_d = next_val_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign val_o  = val_q;
  assign flag_o = flag_q;

endmodule
`default_nettype wire

// ----- rtl/core/sorted_list_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sorted list engine: bounded ordered list of signed 32-bit values.
// Command channel: an item (command, operand) is taken at a rising edge with
// start_i high and busy_o low. Result channel: res_valid_o is high for exactly
// one cycle with res_o; the receiver cannot stall it and needs no handshake.
// The list lives in a row of CAPACITY cells, one entry each, head in cell 0.
// On accept every cell compares its entry with the operand at once and keeps
// a match flag. Searching commands then shift the flags toward the head one
// cell per cycle until cell 0 shows a hit or the end of the list is reached;
// insert and remove move the entries from the write position on by one cell.
// Scan length, counted from the accept edge:
//   append, delete head, unknown codes, and any full/empty case: done in
//   the first scan step, result strobe in the cycle after that.
//   ordered insert, search, delete by key: busy until the scan index is p,
//   the 0-based hit position, or the entry count when there is no hit.
// The next item may be started while the previous result strobe is out.
// The flag shift through the cell row is what sets the scan length.
// Reset (rst_ni low, async) empties the list and clears the strobe; entry
// storage is not cleared, entries beyond the count are never read.
module sorted_list_engine_top #(
  parameter int unsigned CAPACITY = sle_pkg::DefCapacity
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire sle_pkg::sle_cmd_t cmd_i,
  output logic             res_valid_o,
  output sle_pkg::sle_res_t res_o
);
  import sle_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  // control states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic               state_q, state_d;
  logic [2:0]         cmd_q, cmd_d;
  logic signed [31:0] key_q, key_d;
  logic [CW-1:0]      idx_q, idx_d;     // scan position, also the write index
  logic [CW-1:0]      count_q, count_d;
  logic               res_valid_q, res_valid_d;
  sle_res_t           res_q, res_d;

  cell_ctl_t          ctl;
  logic [CW-1:0]      cell_idx;
  logic signed [31:0] cell_key;
  logic signed [31:0] val_w [CAPACITY];
  logic               flag_w [CAPACITY];

  logic               accept;
  logic               done;
  logic [1:0]         st;
  logic signed [31:0] removed;
  logic [CW-1:0]      pos;
  logic [XW-1:0]      pos_x, count_x;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign cell_key = (state_q == S_IDLE) ? cmd_i.operand : key_q;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    idx_d    = idx_q;
    count_d  = count_q;
    ctl.op   = OP_HOLD;
    ctl.cmp_ge = 1'b0;
    cell_idx = idx_q;
    done     = 1'b0;
    st       = STAT_OK;
    removed  = '0;
    pos      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // every cell grabs its compare flag from the incoming operand
          ctl.op     = OP_LOAD;
          ctl.cmp_ge = (cmd_i.command == CMD_INSERT);
          cmd_d      = cmd_i.command;
          key_d      = cmd_i.operand;
          idx_d      = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (cmd_q)
          CMD_APPEND: begin
            done = 1'b1;
            if (count_q == CapVal) begin
              st = STAT_FULL;
            end else begin
              ctl.op   = OP_INSERT;
              cell_idx = count_q;
              count_d  = count_q + 1'b1;
            end
          end
          CMD_INSERT: begin
            priority if (count_q == CapVal) begin
              done = 1'b1;
              st   = STAT_FULL;
            end else if (flag_w[0] || (idx_q == count_q)) begin
              done    = 1'b1;
              ctl.op  = OP_INSERT;
              count_d = count_q + 1'b1;
            end else begin
              ctl.op = OP_SHIFT;
              idx_d  = idx_q + 1'b1;
            end
          end
          CMD_DEL_HD: begin
            done = 1'b1;
            if (count_q == '0) begin
              st = STAT_EMPTY;
            end else begin
              removed  = val_w[0];
              ctl.op   = OP_REMOVE;
              cell_idx = '0;
              count_d  = count_q - 1'b1;
            end
          end
          CMD_SEARCH, CMD_DEL_KEY: begin
            priority if (count_q == '0) begin
              done = 1'b1;
              st   = STAT_EMPTY;
            end else if (idx_q == count_q) begin
              done = 1'b1;
              st   = STAT_NOT_FOUND;
            end else if (flag_w[0]) begin
              done = 1'b1;
              if (cmd_q == CMD_SEARCH) begin
                pos = idx_q + 1'b1;
              end else begin
                // a match means the entry equals the key
                removed = key_q;
                ctl.op  = OP_REMOVE;
                count_d = count_q - 1'b1;
              end
            end else begin
              ctl.op = OP_SHIFT;
              idx_d  = idx_q + 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result formatting; position and count keep their low five bits
  always_comb begin
    pos_x   = XW'(pos);
    count_x = XW'(count_d);
    res_valid_d         = done;
    res_d.status        = st;
    res_d.removed_value = removed;
    res_d.position      = pos_x[4:0];
    res_d.entry_count   = count_x[4:0];
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_v, next_v;
    logic               next_f;
    if (i == 0) begin : g_head
      assign prev_v = cell_key;
    end else begin : g_mid
      assign prev_v = val_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = '0;
      assign next_f = 1'b0;
    end else begin : g_body
      assign next_v = val_w[i+1];
      assign next_f = flag_w[i+1];
    end
    sle_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .idx_i       (cell_idx),
      .count_i     (count_q),
      .key_i       (cell_key),
      .prev_val_i  (prev_v),
      .next_val_i  (next_v),
      .next_flag_i (next_f),
      .val_o       (val_w[i]),
      .flag_o      (flag_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`include "assert_macros.svh"

  `SLE_ASSERT(a_count_bound, count_q <= CapVal, "entry count above capacity")
  `SLE_ASSERT(a_idx_bound, (state_q == S_SCAN) |-> (idx_q <= count_q), "scan ran past the list")
  `SLE_ASSERT(a_accept_scan, accept |=> (state_q == S_SCAN), "accepted item did not start")
  `SLE_ASSERT_NEVER(a_strobe_src, res_valid_q && ($past(state_q) != S_SCAN), "result without work")

endmodule
`default_nettype wire
